@@ hw/rtl/lmtf_pkg.sv @@
// Shared operation and status codes for the move-to-front list.
`timescale 1ns / 1ps
`default_nettype none
package lmtf_pkg;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned DATA_W = 32;

	localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
	localparam logic [OP_W-1:0] OP_FRONT   = 3'd1;
	localparam logic [OP_W-1:0] OP_BACK    = 3'd2;
	localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

endpackage
`default_nettype wire

@@ hw/rtl/list_move_to_front_back_reverse.sv @@
// Append, unknown and empty requests pass through the done state to one registered result.
// Move to front/back: the search reads entries in order until a hit; the entries between
// the hit and the front or back move one place and the value is written there; a miss
// reads all entries. Reverse swaps entry pairs from both ends toward the middle.
// Throughput is set by the single read and single write port of the entry memory.
// Reset clears the entry count and all control; memory contents are not reset.
`timescale 1ns / 1ps
`default_nettype none
module list_move_to_front_back_reverse #(
	parameter int unsigned DEPTH = 64
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [lmtf_pkg::OP_W-1:0]            operation,
	input  wire  signed [lmtf_pkg::DATA_W-1:0]   value,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [lmtf_pkg::DATA_W-1:0]   element,
	output logic [lmtf_pkg::STAT_W-1:0]          status,
	output logic                                 last
);
	import lmtf_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_SRCH     = 13'b0000000000010,
		S_FR_PRIME = 13'b0000000000100,
		S_FR_MOVE  = 13'b0000000001000,
		S_BK_PRIME = 13'b0000000010000,
		S_BK_MOVE  = 13'b0000000100000,
		S_WR_HELD  = 13'b0000001000000,
		S_RV_RD_LO = 13'b0000010000000,
		S_RV_RD_HI = 13'b0000100000000,
		S_RV_WR_LO = 13'b0001000000000,
		S_RV_WR_HI = 13'b0010000000000,
		S_RO       = 13'b0100000000000,
		S_DONE     = 13'b1000000000000
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic [AW-1:0]       hi_q, hi_d;
	logic [DATA_W-1:0]   value_q, value_d;
	logic [DATA_W-1:0]   tmp_q, tmp_d;
	logic                back_q, back_d;
	logic [STAT_W-1:0]   pend_q, pend_d;
	logic                chk_s1, chk_d;
	logic [AW-1:0]       chk_idx_s1, chk_idx_d;

	logic [DATA_W-1:0]   mem [DEPTH];
	logic [DATA_W-1:0]   rdata_q;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [DATA_W-1:0]   wr_data;

	logic                out_valid_q;
	logic [DATA_W-1:0]   element_q;
	logic [STAT_W-1:0]   status_q;
	logic                last_q;
	logic                out_load;
	logic [DATA_W-1:0]   elem_d;
	logic [STAT_W-1:0]   stat_d;
	logic                last_d;

	logic                slot_free;
	logic [AW-1:0]       last_idx;

	assign slot_free = !out_valid_q || out_ready;
	assign last_idx  = AW'(count_q - CW'(1));
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign element   = element_q;
	assign status    = status_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		hi_d      = hi_q;
		value_d   = value_q;
		tmp_d     = tmp_q;
		back_d    = back_q;
		pend_d    = pend_q;
		chk_d     = 1'b0;
		chk_idx_d = chk_idx_s1;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = value_q;
		out_load  = 1'b0;
		elem_d    = '0;
		stat_d    = ST_OK;
		last_d    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = '0;
				if (in_valid) begin
					value_d = value;
					back_d  = (operation == OP_BACK);
					idx_d   = '0;
					state_d = S_DONE;
					pend_d  = ST_OK;
					case (operation)
						OP_APPEND: begin
							if (count_q == CW'(DEPTH)) begin
								pend_d = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = count_q[AW-1:0];
								wr_data = value;
								count_d = count_q + CW'(1);
							end
						end
						OP_FRONT, OP_BACK: begin
							if (count_q == '0) begin
								pend_d = ST_NOT_FOUND;
							end else begin
								state_d = S_SRCH;
							end
						end
						OP_REVERSE: begin
							if (count_q == '0) begin
								pend_d = ST_EMPTY;
							end else if (count_q != CW'(1)) begin
								hi_d    = last_idx;
								state_d = S_RV_RD_LO;
							end
						end
						OP_READ: begin
							if (count_q == '0) begin
								pend_d = ST_EMPTY;
							end else begin
								state_d = S_RO;
							end
						end
						default: begin
							pend_d = ST_OK;
						end
					endcase
				end
			end
			S_SRCH: begin
				if (chk_s1 && rdata_q == value_q) begin
					idx_d = chk_idx_s1;
					if (back_q) begin
						state_d = (chk_idx_s1 == last_idx) ? S_WR_HELD : S_BK_PRIME;
					end else begin
						state_d = (chk_idx_s1 == '0) ? S_WR_HELD : S_FR_PRIME;
					end
				end else if (chk_s1 && chk_idx_s1 == last_idx) begin
					pend_d  = ST_NOT_FOUND;
					state_d = S_DONE;
				end else if (CW'(idx_q) < count_q) begin
					rd_addr   = idx_q;
					chk_d     = 1'b1;
					chk_idx_d = idx_q;
					idx_d     = idx_q + AW'(1);
				end
			end
			S_FR_PRIME: begin
				rd_addr = idx_q - AW'(1);
				state_d = S_FR_MOVE;
			end
			S_FR_MOVE: begin
				wr_en   = 1'b1;
				wr_data = rdata_q;
				if (idx_q == AW'(1)) begin
					idx_d   = '0;
					state_d = S_WR_HELD;
				end else begin
					rd_addr = idx_q - AW'(2);
					idx_d   = idx_q - AW'(1);
				end
			end
			S_BK_PRIME: begin
				rd_addr = idx_q + AW'(1);
				state_d = S_BK_MOVE;
			end
			S_BK_MOVE: begin
				wr_en   = 1'b1;
				wr_data = rdata_q;
				if (idx_q + AW'(1) == last_idx) begin
					idx_d   = last_idx;
					state_d = S_WR_HELD;
				end else begin
					rd_addr = idx_q + AW'(2);
					idx_d   = idx_q + AW'(1);
				end
			end
			S_WR_HELD: begin
				wr_en   = 1'b1;
				pend_d  = ST_OK;
				state_d = S_DONE;
			end
			S_RV_RD_LO: begin
				rd_addr = idx_q;
				state_d = S_RV_RD_HI;
			end
			S_RV_RD_HI: begin
				rd_addr = hi_q;
				tmp_d   = rdata_q;
				state_d = S_RV_WR_LO;
			end
			S_RV_WR_LO: begin
				wr_en   = 1'b1;
				wr_data = rdata_q;
				state_d = S_RV_WR_HI;
			end
			S_RV_WR_HI: begin
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = tmp_q;
				idx_d   = idx_q + AW'(1);
				hi_d    = hi_q - AW'(1);
				if ((idx_q + AW'(1)) < (hi_q - AW'(1))) begin
					state_d = S_RV_RD_LO;
				end else begin
					pend_d  = ST_OK;
					state_d = S_DONE;
				end
			end
			S_RO: begin
				if (slot_free) begin
					out_load = 1'b1;
					elem_d   = rdata_q;
					last_d   = (idx_q == last_idx);
					if (idx_q == last_idx) begin
						state_d = S_IDLE;
					end else begin
						rd_addr = idx_q + AW'(1);
						idx_d   = idx_q + AW'(1);
					end
				end
			end
			S_DONE: begin
				if (slot_free) begin
					out_load = 1'b1;
					stat_d   = pend_q;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			hi_q        <= '0;
			back_q      <= 1'b0;
			pend_q      <= ST_OK;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			hi_q    <= hi_d;
			back_q  <= back_d;
			pend_q  <= pend_d;
			chk_s1  <= chk_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q    <= value_d;
		tmp_q      <= tmp_d;
		chk_idx_s1 <= chk_idx_d;
		if (out_load) begin
			element_q <= elem_d;
			status_q  <= stat_d;
			last_q    <= last_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/lmtf_checker.sv @@
// Port-level checker for the move-to-front list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lmtf_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 in_valid,
	input wire                                 in_ready,
	input wire                                 out_valid,
	input wire                                 out_ready,
	input wire signed [lmtf_pkg::DATA_W-1:0]   element,
	input wire [lmtf_pkg::STAT_W-1:0]          status,
	input wire                                 last
);
	import lmtf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(element) && $stable(status)
			&& $stable(last))
		else $error("result changed while stalled");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new request taken before previous one finished");

	a_nonfinal_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_OK)
		else $error("non-final result carries a non-ok status");

	a_element_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && element != 0 |-> status == ST_OK)
		else $error("element returned with a non-ok status");

endmodule

bind list_move_to_front_back_reverse lmtf_checker u_lmtf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.element   (element),
	.status    (status),
	.last      (last)
);
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the move-to-front list: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;
	import lmtf_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int NDIR = 23;
	localparam int PHASE_ITEMS = 95;
	localparam int DRAIN_CYCLES = 200;
	localparam int STUCK_LIMIT = 5000;

	localparam logic [OP_W-1:0] OP_SPARE0 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE1 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE2 = 3'd7;

	localparam logic [DATA_W-1:0] V_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] V_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] V_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic [STAT_W-1:0] status;
		logic last;
	} list_res_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [DATA_W-1:0] value;
		logic typed;
		logic [STAT_W-1:0] st;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [OP_W-1:0] operation = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic out_ready = 1'b0;
	wire in_ready;
	wire out_valid;
	wire signed [DATA_W-1:0] element;
	wire [STAT_W-1:0] status;
	wire last;

	list_move_to_front_back_reverse #(.DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.element(element),
		.status(status),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dir_row_t dir_tab [0:NDIR-1] = '{
		'{OP_READ,    32'h0000_0000, 1'b1, ST_EMPTY},
		'{OP_REVERSE, 32'h0000_1234, 1'b1, ST_EMPTY},
		'{OP_FRONT,   32'h0000_0000, 1'b1, ST_NOT_FOUND},
		'{OP_BACK,    V_ONES,        1'b1, ST_NOT_FOUND},
		'{OP_SPARE0,  32'h0000_0000, 1'b1, ST_OK},
		'{OP_SPARE2,  V_ONES,        1'b1, ST_OK},
		'{OP_APPEND,  V_MIN,         1'b1, ST_OK},
		'{OP_APPEND,  V_MAX,         1'b1, ST_OK},
		'{OP_APPEND,  32'h0000_0000, 1'b1, ST_OK},
		'{OP_APPEND,  V_ONES,        1'b1, ST_OK},
		'{OP_APPEND,  32'h0000_0000, 1'b1, ST_OK},
		'{OP_READ,    32'h0000_0000, 1'b0, ST_OK},
		'{OP_FRONT,   32'h0000_0000, 1'b0, ST_OK},
		'{OP_READ,    V_ONES,        1'b0, ST_OK},
		'{OP_BACK,    V_MIN,         1'b0, ST_OK},
		'{OP_BACK,    V_ONES,        1'b0, ST_OK},
		'{OP_FRONT,   V_MAX,         1'b0, ST_OK},
		'{OP_REVERSE, V_ONES,        1'b0, ST_OK},
		'{OP_READ,    32'h0000_0000, 1'b0, ST_OK},
		'{OP_FRONT,   32'h0000_0001, 1'b1, ST_NOT_FOUND},
		'{OP_BACK,    32'h7FFF_FFFE, 1'b1, ST_NOT_FOUND},
		'{OP_SPARE1,  32'h5A5A_A5A5, 1'b1, ST_OK},
		'{OP_READ,    32'h0000_0000, 1'b0, ST_OK}
	};

	logic signed [DATA_W-1:0] lst [0:DEPTH-1];
	int unsigned lst_cnt = 0;
	list_res_t step_res [$];
	list_res_t pending [$];
	list_res_t head;

	int errors = 0;
	int reqs_sent = 0;
	int results_checked = 0;
	int reads_sent = 0;
	int full_refusals = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit quiet = 1'b0;
	int stuck_cycles = 0;

	function automatic list_res_t one_res(input logic [STAT_W-1:0] st);
		list_res_t r;
		r.element = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic step_list(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
		int unsigned pos;
		int unsigned i;
		logic signed [DATA_W-1:0] held;
		list_res_t r;
		step_res.delete();
		pos = lst_cnt;
		for (i = 0; i < lst_cnt; i++) begin
			if (pos == lst_cnt && lst[i] == val)
				pos = i;
		end
		case (op)
			OP_APPEND: begin
				if (lst_cnt >= DEPTH) begin
					step_res.push_back(one_res(ST_FULL));
					full_refusals++;
				end else begin
					lst[lst_cnt] = val;
					lst_cnt++;
					step_res.push_back(one_res(ST_OK));
				end
			end
			OP_FRONT: begin
				if (pos >= lst_cnt) begin
					step_res.push_back(one_res(ST_NOT_FOUND));
				end else begin
					held = lst[pos];
					for (i = pos; i > 0; i--)
						lst[i] = lst[i-1];
					lst[0] = held;
					step_res.push_back(one_res(ST_OK));
				end
			end
			OP_BACK: begin
				if (pos >= lst_cnt) begin
					step_res.push_back(one_res(ST_NOT_FOUND));
				end else begin
					held = lst[pos];
					for (i = pos; i + 1 < lst_cnt; i++)
						lst[i] = lst[i+1];
					lst[lst_cnt-1] = held;
					step_res.push_back(one_res(ST_OK));
				end
			end
			OP_REVERSE: begin
				if (lst_cnt == 0) begin
					step_res.push_back(one_res(ST_EMPTY));
				end else begin
					for (i = 0; i < lst_cnt / 2; i++) begin
						held = lst[i];
						lst[i] = lst[lst_cnt-1-i];
						lst[lst_cnt-1-i] = held;
					end
					step_res.push_back(one_res(ST_OK));
				end
			end
			OP_READ: begin
				if (lst_cnt == 0) begin
					step_res.push_back(one_res(ST_EMPTY));
				end else begin
					for (i = 0; i < lst_cnt; i++) begin
						r.element = lst[i];
						r.status = ST_OK;
						r.last = (i + 1 == lst_cnt);
						step_res.push_back(r);
					end
				end
			end
			default: begin
				step_res.push_back(one_res(ST_OK));
			end
		endcase
	endtask

	task automatic send_req(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
			input bit typed, input logic [STAT_W-1:0] st);
		while (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		step_list(op, val);
		if (typed)
			pending.push_back(one_res(st));
		else
			foreach (step_res[i])
				pending.push_back(step_res[i]);
		reqs_sent++;
		if (op == OP_READ)
			reads_sent++;
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value(input logic [OP_W-1:0] op);
		int r;
		r = $urandom_range(0, 99);
		if ((op == OP_FRONT || op == OP_BACK) && lst_cnt > 0 && r < 60)
			return lst[$urandom_range(0, lst_cnt - 1)];
		if (op == OP_APPEND && lst_cnt > 0 && r < 35)
			return lst[$urandom_range(0, lst_cnt - 1)];
		if (r < 72) begin
			case ($urandom_range(0, 3))
				0: return V_MIN;
				1: return V_MAX;
				2: return '0;
				default: return V_ONES;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 22)
			return OP_APPEND;
		if (r < 44)
			return OP_FRONT;
		if (r < 64)
			return OP_BACK;
		if (r < 76)
			return OP_REVERSE;
		if (r < 91)
			return OP_READ;
		case ($urandom_range(0, 2))
			0: return OP_SPARE0;
			1: return OP_SPARE1;
			default: return OP_SPARE2;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$error("unexpected result: element %0d status %0d last %0d",
					element, status, last);
				errors++;
			end else begin
				head = pending.pop_front();
				if (element !== head.element) begin
					$error("element: expected %0d, got %0d", head.element, element);
					errors++;
				end
				if (status !== head.status) begin
					$error("status: expected %0d, got %0d", head.status, status);
					errors++;
				end
				if (last !== head.last) begin
					$error("last: expected %0d, got %0d", head.last, last);
					errors++;
				end
				results_checked++;
			end
		end
		out_ready <= quiet || ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		quiet = 1'b1;
		for (int n = 0; n < NDIR; n++)
			send_req(dir_tab[n].op, dir_tab[n].value, dir_tab[n].typed, dir_tab[n].st);
		hold_until_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
				default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				logic [OP_W-1:0] op;
				quiet = (k % 32) >= 24;
				op = pick_op();
				send_req(op, pick_value(op), 1'b0, ST_OK);
			end
			hold_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending.size() != 0) begin
			$error("%0d expected results never arrived", pending.size());
			errors++;
		end
		$display("covered %0d requests (%0d read outs, %0d refused appends), %0d results checked",
			reqs_sent, reads_sent, full_refusals, results_checked);
		$display("list held %0d entries at the end, %0d mismatches", lst_cnt, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ list_move_to_front_back_reverse.f @@
hw/rtl/lmtf_pkg.sv
hw/rtl/list_move_to_front_back_reverse.sv
hw/rtl/lmtf_checker.sv
sim/tb.sv
